@@ hw/rtl/dcrk_pkg.sv @@
// Shared types and codes for the DC motor RK4 step engine.
// Holds the controller states, datapath command encoding and register indexes.
// No dependencies.
package dcrk_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STATE_W    = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPEED_FROM_SPEED     = 3'd0,
    REG_SPEED_FROM_CURRENT   = 3'd1,
    REG_CURRENT_FROM_SPEED   = 3'd2,
    REG_CURRENT_FROM_CURRENT = 3'd3,
    REG_CURRENT_FROM_VOLTAGE = 3'd4,
    REG_STEP_SIZE            = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_STAGE,
    ST_FINAL,
    ST_DIV,
    ST_DONE
  } state_e;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SS,
    MUL_SC,
    MUL_CS,
    MUL_CC,
    MUL_CV,
    MUL_H_K,
    MUL_H_HI,
    MUL_H_LO
  } mul_op_e;

  // What is done with the registered product.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_RAW,
    ACC_K_SPEED,
    ACC_K_CURRENT,
    ACC_STAGE,
    ACC_FINISH
  } acc_op_e;

  typedef enum logic [1:0] {
    KS_NONE,
    KS_LOAD,
    KS_ADD1,
    KS_ADD2
  } ksum_op_e;

  typedef logic [1:0] lane_t;

  localparam lane_t LANE_ANGLE   = 2'd0;
  localparam lane_t LANE_SPEED   = 2'd1;
  localparam lane_t LANE_CURRENT = 2'd2;

  typedef struct packed {
    logic     load;
    mul_op_e  mul_op;
    lane_t    mul_lane;
    acc_op_e  acc_op;
    lane_t    acc_lane;
    logic     half_step;
    ksum_op_e ksum_op;
    logic     div_step;
    logic     commit;
  } dcrk_cmd_t;

endpackage

@@ hw/rtl/dcrk_datapath.sv @@
// Datapath of the RK4 step engine: coefficient registers, motor state,
// stage state, slopes, the shared multiplier and three divide-by-three lanes.
// Depends on dcrk_pkg; driven cycle by cycle by dcrk_ctrl.
module dcrk_datapath #(
  parameter int unsigned STATE_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [dcrk_pkg::CFG_ADDR_W-1:0]     cfg_index_i,
  input  logic [dcrk_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [dcrk_pkg::STATE_W-1:0]        in_data_i,
  input  dcrk_pkg::dcrk_cmd_t                 cmd_i,
  output logic [dcrk_pkg::STATE_W-1:0]        angle_o,
  output logic [dcrk_pkg::STATE_W-1:0]        speed_o,
  output logic [dcrk_pkg::STATE_W-1:0]        current_o
);

  localparam int unsigned PW         = 66;
  localparam int unsigned SUM_W      = 35;
  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned COEF_FRAC  = 24;
  localparam int unsigned VOLT_SHIFT = COEF_FRAC + 16 - STATE_FRAC_BITS;
  localparam int unsigned HI_SHIFT   = 17;

  localparam logic signed [PW-1:0] SAT_MAX  = 66'sd2147483647;
  localparam logic signed [PW-1:0] SAT_MIN  = -66'sd2147483648;
  localparam logic signed [PW-1:0] DIV_BIAS = 66'sd6442450944;
  localparam logic signed [PW-1:0] INC_BIAS = 66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0]       css_q, csc_q, ccs_q, ccc_q, ccv_q;
  logic [23:0]              step_q;
  logic signed [31:0]       x_q [3];
  logic signed [31:0]       xs_q [3];
  logic signed [31:0]       k_q [3];
  logic signed [SUM_W-1:0]  ksum_q [3];
  logic signed [31:0]       u_q;
  logic signed [PW-1:0]     prod_q, prod_d;
  logic signed [PW-1:0]     acc_q;
  logic [DIV_W-1:0]         div_n_q [3];
  logic [DIV_W-1:0]         div_n_d [3];
  logic [1:0]               div_r_q [3];
  logic [1:0]               div_r_d [3];

  logic signed [32:0]       op_a, op_b;
  logic signed [PW-1:0]     p_coef, p_volt, stage_sum, fin_raw, fin;
  logic signed [PW-1:0]     x_lane;
  logic signed [PW-1:0]     commit_sum [3];

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_op)
      dcrk_pkg::MUL_SS: begin
        op_a = {css_q[31], css_q};
        op_b = {xs_q[1][31], xs_q[1]};
      end
      dcrk_pkg::MUL_SC: begin
        op_a = {csc_q[31], csc_q};
        op_b = {xs_q[2][31], xs_q[2]};
      end
      dcrk_pkg::MUL_CS: begin
        op_a = {ccs_q[31], ccs_q};
        op_b = {xs_q[1][31], xs_q[1]};
      end
      dcrk_pkg::MUL_CC: begin
        op_a = {ccc_q[31], ccc_q};
        op_b = {xs_q[2][31], xs_q[2]};
      end
      dcrk_pkg::MUL_CV: begin
        op_a = {ccv_q[31], ccv_q};
        op_b = {u_q[31], u_q};
      end
      dcrk_pkg::MUL_H_K: begin
        op_a = {9'd0, step_q};
        op_b = {k_q[cmd_i.mul_lane][31], k_q[cmd_i.mul_lane]};
      end
      dcrk_pkg::MUL_H_HI: begin
        op_a = {9'd0, step_q};
        op_b = {{15{ksum_q[cmd_i.mul_lane][SUM_W-1]}},
                ksum_q[cmd_i.mul_lane][SUM_W-1:HI_SHIFT]};
      end
      dcrk_pkg::MUL_H_LO: begin
        op_a = {9'd0, step_q};
        op_b = {16'd0, ksum_q[cmd_i.mul_lane][HI_SHIFT-1:0]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_d = op_a * op_b;
  end

  // Post-multiply arithmetic. Arithmetic right shifts give floor rounding.
  always_comb begin
    p_coef    = prod_q >>> COEF_FRAC;
    p_volt    = prod_q >>> VOLT_SHIFT;
    x_lane    = {{(PW-32){x_q[cmd_i.acc_lane][31]}}, x_q[cmd_i.acc_lane]};
    stage_sum = x_lane + (cmd_i.half_step ? (prod_q >>> (COEF_FRAC + 1))
                                          : (prod_q >>> COEF_FRAC));
    // The weighted slope sum was multiplied in two halves; the extra bit of
    // shift folds the factor two of the divisor six into the floor.
    fin_raw   = (acc_q <<< HI_SHIFT) + prod_q;
    fin       = (fin_raw >>> (COEF_FRAC + 1)) + DIV_BIAS;
    for (int i = 0; i < 3; i++) begin
      commit_sum[i] = {{(PW-32){x_q[i][31]}}, x_q[i]}
                    + $signed({34'd0, div_n_q[i][31:0]}) - INC_BIAS;
    end
  end

  // Restoring division by three, several quotient bits per cycle on each lane while div_step is set.
  always_comb begin
    logic [DIV_W-1:0] n;
    logic [1:0]       r;
    logic [2:0]       t;
    logic             qb;
    for (int l = 0; l < 3; l++) begin
      n = div_n_q[l];
      r = div_r_q[l];
      for (int b = 0; b < DIV_BITS; b++) begin
        t  = {r, n[DIV_W-1]};
        qb = (t >= 3'd3);
        r  = qb ? 2'(t - 3'd3) : t[1:0];
        n  = {n[DIV_W-2:0], qb};
      end
      div_n_d[l] = n;
      div_r_d[l] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      css_q  <= '0;
      csc_q  <= '0;
      ccs_q  <= '0;
      ccc_q  <= '0;
      ccv_q  <= '0;
      step_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcrk_pkg::REG_SPEED_FROM_SPEED:     css_q  <= cfg_data_i;
        dcrk_pkg::REG_SPEED_FROM_CURRENT:   csc_q  <= cfg_data_i;
        dcrk_pkg::REG_CURRENT_FROM_SPEED:   ccs_q  <= cfg_data_i;
        dcrk_pkg::REG_CURRENT_FROM_CURRENT: ccc_q  <= cfg_data_i;
        dcrk_pkg::REG_CURRENT_FROM_VOLTAGE: ccv_q  <= cfg_data_i;
        dcrk_pkg::REG_STEP_SIZE:            step_q <= cfg_data_i[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        x_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < 3; i++) begin
        x_q[i] <= sat32(commit_sum[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;

    if (cmd_i.load) begin
      u_q <= in_data_i;
      for (int i = 0; i < 3; i++) begin
        xs_q[i] <= x_q[i];
      end
    end

    case (cmd_i.acc_op)
      dcrk_pkg::ACC_LOAD: acc_q <= p_coef;
      dcrk_pkg::ACC_ADD:  acc_q <= acc_q + p_coef;
      dcrk_pkg::ACC_RAW:  acc_q <= prod_q;
      dcrk_pkg::ACC_K_SPEED: begin
        k_q[1] <= sat32(acc_q + p_coef);
      end
      dcrk_pkg::ACC_K_CURRENT: begin
        k_q[2] <= sat32(acc_q + p_volt);
        k_q[0] <= xs_q[1];
      end
      dcrk_pkg::ACC_STAGE: begin
        xs_q[cmd_i.acc_lane] <= sat32(stage_sum);
      end
      dcrk_pkg::ACC_FINISH: begin
        div_n_q[cmd_i.acc_lane] <= {6'd0, fin[33:0]};
        div_r_q[cmd_i.acc_lane] <= 2'd0;
      end
      default: begin
      end
    endcase

    if (cmd_i.div_step) begin
      for (int l = 0; l < 3; l++) begin
        div_n_q[l] <= div_n_d[l];
        div_r_q[l] <= div_r_d[l];
      end
    end

    for (int i = 0; i < 3; i++) begin
      case (cmd_i.ksum_op)
        dcrk_pkg::KS_LOAD: ksum_q[i] <= {{3{k_q[i][31]}}, k_q[i]};
        dcrk_pkg::KS_ADD1: ksum_q[i] <= ksum_q[i] + {{3{k_q[i][31]}}, k_q[i]};
        dcrk_pkg::KS_ADD2: ksum_q[i] <= ksum_q[i] + {{2{k_q[i][31]}}, k_q[i], 1'b0};
        default: begin
        end
      endcase
    end
  end

  assign angle_o   = x_q[0];
  assign speed_o   = x_q[1];
  assign current_o = x_q[2];

endmodule

@@ hw/rtl/dcrk_ctrl.sv @@
// Sequencer of the RK4 step engine: walks the four slope passes, the stage
// updates, the final weighted sum and the division, and owns both handshakes.
// Depends on dcrk_pkg.
module dcrk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcrk_pkg::dcrk_cmd_t cmd_o
);

  dcrk_pkg::state_e state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       pass_q, pass_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 3'd1;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      dcrk_pkg::ST_IDLE: begin
        cnt_d  = 3'd0;
        pass_d = 2'd0;
        if (in_valid_i) begin
          state_d = dcrk_pkg::ST_SLOPE;
        end
      end
      dcrk_pkg::ST_SLOPE: begin
        if (cnt_q == 3'd5) begin
          cnt_d   = 3'd0;
          state_d = (pass_q == 2'd3) ? dcrk_pkg::ST_FINAL : dcrk_pkg::ST_STAGE;
        end
      end
      dcrk_pkg::ST_STAGE: begin
        if (cnt_q == 3'd3) begin
          cnt_d   = 3'd0;
          pass_d  = pass_q + 2'd1;
          state_d = dcrk_pkg::ST_SLOPE;
        end
      end
      dcrk_pkg::ST_FINAL: begin
        if (cnt_q == 3'd7) begin
          cnt_d   = 3'd0;
          state_d = dcrk_pkg::ST_DIV;
        end
      end
      dcrk_pkg::ST_DIV: begin
        if (cnt_q == 3'd4) begin
          cnt_d   = 3'd0;
          state_d = dcrk_pkg::ST_DONE;
        end
      end
      dcrk_pkg::ST_DONE: begin
        cnt_d = 3'd0;
        // The result is shown straight from the state registers, so the
        // commit waits until the previous result has left.
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = dcrk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcrk_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load      = 1'b0;
    cmd_o.mul_op    = dcrk_pkg::MUL_NONE;
    cmd_o.mul_lane  = dcrk_pkg::LANE_ANGLE;
    cmd_o.acc_op    = dcrk_pkg::ACC_NONE;
    cmd_o.acc_lane  = dcrk_pkg::LANE_ANGLE;
    cmd_o.half_step = (pass_q != 2'd2);
    cmd_o.ksum_op   = dcrk_pkg::KS_NONE;
    cmd_o.div_step  = 1'b0;
    cmd_o.commit    = 1'b0;
    in_ready_o      = 1'b0;
    case (state_q)
      dcrk_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      dcrk_pkg::ST_SLOPE: begin
        case (cnt_q)
          3'd0: cmd_o.mul_op = dcrk_pkg::MUL_SS;
          3'd1: begin
            cmd_o.mul_op = dcrk_pkg::MUL_SC;
            cmd_o.acc_op = dcrk_pkg::ACC_LOAD;
          end
          3'd2: begin
            cmd_o.mul_op = dcrk_pkg::MUL_CS;
            cmd_o.acc_op = dcrk_pkg::ACC_K_SPEED;
          end
          3'd3: begin
            cmd_o.mul_op = dcrk_pkg::MUL_CC;
            cmd_o.acc_op = dcrk_pkg::ACC_LOAD;
          end
          3'd4: begin
            cmd_o.mul_op = dcrk_pkg::MUL_CV;
            cmd_o.acc_op = dcrk_pkg::ACC_ADD;
          end
          3'd5: cmd_o.acc_op = dcrk_pkg::ACC_K_CURRENT;
          default: begin
          end
        endcase
      end
      dcrk_pkg::ST_STAGE: begin
        case (cnt_q)
          3'd0: begin
            cmd_o.ksum_op  = (pass_q == 2'd0) ? dcrk_pkg::KS_LOAD : dcrk_pkg::KS_ADD2;
            cmd_o.mul_op   = dcrk_pkg::MUL_H_K;
            cmd_o.mul_lane = dcrk_pkg::LANE_ANGLE;
          end
          3'd1: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_K;
            cmd_o.mul_lane = dcrk_pkg::LANE_SPEED;
            cmd_o.acc_op   = dcrk_pkg::ACC_STAGE;
            cmd_o.acc_lane = dcrk_pkg::LANE_ANGLE;
          end
          3'd2: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_K;
            cmd_o.mul_lane = dcrk_pkg::LANE_CURRENT;
            cmd_o.acc_op   = dcrk_pkg::ACC_STAGE;
            cmd_o.acc_lane = dcrk_pkg::LANE_SPEED;
          end
          3'd3: begin
            cmd_o.acc_op   = dcrk_pkg::ACC_STAGE;
            cmd_o.acc_lane = dcrk_pkg::LANE_CURRENT;
          end
          default: begin
          end
        endcase
      end
      dcrk_pkg::ST_FINAL: begin
        case (cnt_q)
          3'd0: cmd_o.ksum_op = dcrk_pkg::KS_ADD1;
          3'd1: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_HI;
            cmd_o.mul_lane = dcrk_pkg::LANE_ANGLE;
          end
          3'd2: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_LO;
            cmd_o.mul_lane = dcrk_pkg::LANE_ANGLE;
            cmd_o.acc_op   = dcrk_pkg::ACC_RAW;
          end
          3'd3: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_HI;
            cmd_o.mul_lane = dcrk_pkg::LANE_SPEED;
            cmd_o.acc_op   = dcrk_pkg::ACC_FINISH;
            cmd_o.acc_lane = dcrk_pkg::LANE_ANGLE;
          end
          3'd4: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_LO;
            cmd_o.mul_lane = dcrk_pkg::LANE_SPEED;
            cmd_o.acc_op   = dcrk_pkg::ACC_RAW;
          end
          3'd5: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_HI;
            cmd_o.mul_lane = dcrk_pkg::LANE_CURRENT;
            cmd_o.acc_op   = dcrk_pkg::ACC_FINISH;
            cmd_o.acc_lane = dcrk_pkg::LANE_SPEED;
          end
          3'd6: begin
            cmd_o.mul_op   = dcrk_pkg::MUL_H_LO;
            cmd_o.mul_lane = dcrk_pkg::LANE_CURRENT;
            cmd_o.acc_op   = dcrk_pkg::ACC_RAW;
          end
          3'd7: begin
            cmd_o.acc_op   = dcrk_pkg::ACC_FINISH;
            cmd_o.acc_lane = dcrk_pkg::LANE_CURRENT;
          end
          default: begin
          end
        endcase
      end
      dcrk_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      dcrk_pkg::ST_DONE: cmd_o.commit = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcrk_pkg::ST_IDLE;
      cnt_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dcrk_pkg::ST_DONE))
    else $error("result became valid outside the commit step");

  a_no_commit_over_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.commit)
    else $error("state committed while the previous result was still waiting");

  a_slope_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcrk_pkg::ST_SLOPE) |-> (cnt_q <= 3'd5))
    else $error("slope sub-step counter out of range");

  a_final_after_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcrk_pkg::ST_FINAL) |-> (pass_q == 2'd3))
    else $error("final sum started before the fourth slope");
`endif

endmodule

@@ hw/rtl/dc_motor_rk4_step.sv @@
// DC motor RK4 step: one drive-voltage sample in, the new (angle, speed, current) out.
// A new sample is taken only in idle, once the previous step has committed; the work runs on
// the single shared 33x33 multiplier (four slope passes, three stage updates, a final sum),
// then the divide-by-three lanes, and the commit waits until the last result is taken.
// Reset (rst_ni low, asynchronous) clears the motor state and all coefficient registers.
// Depends on dcrk_pkg, dcrk_ctrl and dcrk_datapath.
module dc_motor_rk4_step #(
  parameter int unsigned STATE_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dcrk_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [dcrk_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // [31:0] drive_voltage
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [95:0]                     m_axis_tdata   // [31:0] shaft_angle,
                                                         // [63:32] shaft_speed,
                                                         // [95:64] winding_current
);

  dcrk_pkg::dcrk_cmd_t cmd;
  logic [dcrk_pkg::STATE_W-1:0] angle, speed, current;

  assign cfg_ready_o = 1'b1;

  dcrk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  dcrk_datapath #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .angle_o     (angle),
    .speed_o     (speed),
    .current_o   (current)
  );

  assign m_axis_tdata = {current, speed, angle};

endmodule
